// ----- hw/rtl/base64_codec_core_defines.svh -----
// Assertion macros used by the base64 codec job queue
`ifndef BASE64_CODEC_CORE_DEFINES_SVH
`define BASE64_CODEC_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define B64C_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define B64C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/b64c_pkg.sv -----
// Package: job descriptor, queue sizing and alphabet mapping for the base64 codec
package b64c_pkg;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic       MODE_ENC = 1'b0;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            last;
    logic            dv;
    logic            err;
  } job_t;

  typedef struct packed {
    logic       pad;
    logic       bad;
    logic [5:0] sext;
  } dec_t;

  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] e;
    logic [7:0] r;
    e = {2'b00, s};
    if (s < 6'd26) begin
      r = 8'h41 + e;
    end else if (s < 6'd52) begin
      r = 8'h61 + e - 8'd26;
    end else if (s < 6'd62) begin
      r = 8'h30 + e - 8'd52;
    end else if (s == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  function automatic dec_t dec_char(input logic [7:0] c);
    dec_t d;
    d = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d.sext = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d.sext = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d.sext = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      d.sext = 6'd62;
    end else if (c == 8'h2F) begin
      d.sext = 6'd63;
    end else if (c == PAD_CHAR) begin
      d.pad = 1'b1;
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

  // Bytes of n held sextets in v, closing the stream
  function automatic job_t flush_job(input logic [23:0] v, input logic [2:0] n);
    job_t j;
    j      = '0;
    j.last = 1'b1;
    j.dv   = 1'b1;
    case (n)
      3'd4: begin
        j.bytes[0] = v[23:16];
        j.bytes[1] = v[15:8];
        j.bytes[2] = v[7:0];
        j.last_idx = 2'd2;
      end
      3'd3: begin
        j.bytes[0] = v[17:10];
        j.bytes[1] = v[9:2];
        j.last_idx = 2'd1;
      end
      3'd2: begin
        j.bytes[0] = v[11:4];
        j.last_idx = 2'd0;
      end
      default: begin
        j.dv       = 1'b0;
        j.last_idx = 2'd0;
      end
    endcase
    return j;
  endfunction

endpackage

// ----- hw/rtl/b64c_front.sv -----
// Front end: accept items, track the group state and build result jobs
module b64c_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              push,
  output b64c_pkg::job_t    job
);

  logic        mode_r, mode_nxt;
  logic [1:0]  gp_r, gp_nxt;
  logic [17:0] held_r, held_nxt;
  logic        drop_r, drop_nxt;

  logic           accept;
  logic           job_valid;
  logic [2:0]     cnt;
  logic [23:0]    ve, vs, vd;
  b64c_pkg::dec_t dc;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && job_valid;

  always_comb begin
    mode_nxt  = mode_r;
    gp_nxt    = gp_r;
    held_nxt  = held_r;
    drop_nxt  = drop_r;
    job_valid = 1'b0;
    job       = '0;
    cnt       = {1'b0, gp_r} + 3'd1;
    ve        = {held_r[15:0], in_tdata};
    vd        = {held_r, 6'b0};
    vs        = ve;
    dc        = b64c_pkg::dec_char(in_tdata);
    if (accept) begin
      if (drop_r) begin
        if (in_tlast) begin
          drop_nxt = 1'b0;
          gp_nxt   = '0;
          held_nxt = '0;
        end
      end else if (mode_r == b64c_pkg::MODE_ENC) begin
        if (cnt < 3'd3 && !in_tlast) begin
          held_nxt = {2'b00, ve[15:0]};
          gp_nxt   = cnt[1:0];
        end else begin
          if (cnt == 3'd1) begin
            vs = ve << 16;
          end else if (cnt == 3'd2) begin
            vs = ve << 8;
          end
          gp_nxt       = '0;
          held_nxt     = '0;
          job_valid    = 1'b1;
          job.bytes[0] = b64c_pkg::enc_char(vs[23:18]);
          job.bytes[1] = b64c_pkg::enc_char(vs[17:12]);
          job.bytes[2] = (cnt >= 3'd2) ? b64c_pkg::enc_char(vs[11:6]) : b64c_pkg::PAD_CHAR;
          job.bytes[3] = (cnt >= 3'd3) ? b64c_pkg::enc_char(vs[5:0]) : b64c_pkg::PAD_CHAR;
          job.last_idx = 2'd3;
          job.last     = in_tlast;
          job.dv       = 1'b1;
        end
      end else begin
        vd = {held_r, dc.sext};
        if (dc.bad) begin
          gp_nxt    = '0;
          held_nxt  = '0;
          drop_nxt  = !in_tlast;
          job_valid = 1'b1;
          job.last  = 1'b1;
          job.err   = 1'b1;
        end else if (dc.pad) begin
          job       = b64c_pkg::flush_job({6'b0, held_r}, {1'b0, gp_r});
          job_valid = 1'b1;
          gp_nxt    = '0;
          held_nxt  = '0;
          drop_nxt  = !in_tlast;
        end else if (in_tlast) begin
          job       = b64c_pkg::flush_job(vd, cnt);
          job_valid = 1'b1;
          gp_nxt    = '0;
          held_nxt  = '0;
        end else if (cnt < 3'd4) begin
          held_nxt = vd[17:0];
          gp_nxt   = cnt[1:0];
        end else begin
          gp_nxt       = '0;
          held_nxt     = '0;
          job_valid    = 1'b1;
          job.bytes[0] = vd[23:16];
          job.bytes[1] = vd[15:8];
          job.bytes[2] = vd[7:0];
          job.last_idx = 2'd2;
          job.dv       = 1'b1;
        end
      end
    end
    if (cfg_wr_en) begin
      mode_nxt = cfg_wr_data;
      gp_nxt   = '0;
      held_nxt = '0;
      drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= b64c_pkg::MODE_ENC;
      gp_r   <= '0;
      held_r <= '0;
      drop_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      gp_r   <= gp_nxt;
      held_r <= held_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

// ----- hw/rtl/b64c_queue.sv -----
// Job queue between the front end and the result sequencer
`include "base64_codec_core_defines.svh"

module b64c_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64c_pkg::job_t job_in,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output b64c_pkg::job_t job_out
);

  b64c_pkg::job_t                      mem_r [b64c_pkg::Q_DEPTH];
  logic [b64c_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [b64c_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [b64c_pkg::QCNT_W-1:0]         count_r, count_nxt;

  assign full    = (count_r == b64c_pkg::QCNT_W'(b64c_pkg::Q_DEPTH));
  assign valid   = (count_r != '0);
  assign job_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == b64c_pkg::QPTR_W'(b64c_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == b64c_pkg::QPTR_W'(b64c_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  `B64C_ASSERT_IMP(a_no_push_full, push, !full, "job pushed into a full queue")
  `B64C_ASSERT_IMP(a_no_pop_empty, pop, valid, "job popped from an empty queue")
  `B64C_ASSERT_NEXT(a_push_holds, push && !pop, count_r != '0, "pushed job lost")

endmodule

// ----- hw/rtl/b64c_back.sv -----
// Result sequencer: walk each job's entries into the output register
module b64c_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  b64c_pkg::job_t job,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic [1:0]     out_tuser
);

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] data_r;
  logic       last_r, dv_r, err_r;
  logic       load;

  assign load = q_valid && (!valid_r || out_tready);
  assign pop  = load && (idx_r == job.last_idx);

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = pop ? 2'd0 : idx_r + 2'd1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= job.bytes[idx_r];
      last_r <= job.last && (idx_r == job.last_idx);
      dv_r   <= job.dv;
      err_r  <= job.err;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = {err_r, dv_r};

endmodule

// ----- hw/rtl/base64_codec_core.sv -----
// Base64 codec top level: front end, job queue and result sequencer
// Path: the first result of an item is registered in the job queue, then in the output register.
// Throughput: one item per cycle while the queue has room; one result per cycle out of the
// output register while out_tready is high; encode makes four results per three items.
// Reset: synchronous active-low rst_n; mode returns to encode, group state and queue clear.
module base64_codec_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_in
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_out
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [0] data_valid, [1] error
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  b64c_pkg::job_t job_in;
  b64c_pkg::job_t job_out;

  b64c_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_full     (q_full),
    .push       (q_push),
    .job        (job_in)
  );

  b64c_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .job_in (job_in),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .job_out(job_out)
  );

  b64c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .job       (job_out),
    .pop       (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

// ----- tb/base64_codec_core_test.sv -----
// Self-checking testbench for the base64 codec core: encode and decode streams against a predictor
`timescale 1ns / 1ps

module base64_codec_core_test;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PERCENT = 36;
  localparam int SEXTET_PAD   = 64;
  localparam int SEXTET_BAD   = 65;

  typedef struct packed {
    logic [7:0] data;
    logic       dv;
    logic       last;
    logic       err;
  } b64_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  b64_result_t base64_expected[$];

  logic        pred_mode  = b64c_pkg::MODE_ENC;
  logic [1:0]  pred_count = 2'd0;
  logic [17:0] pred_held  = 18'd0;
  logic        pred_drop  = 1'b0;

  int  fails = 0;
  int  items_sent = 0;
  int  items_live = 0;
  int  results_seen = 0;
  int  error_results = 0;
  int  stall_count = 0;
  int  hold_left = 0;
  bit  hold_request = 1'b0;
  bit  steady = 1'b0;

  base64_codec_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int sextet_of(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (b64_alphabet[i] == c) return i;
    end
    if (c == b64c_pkg::PAD_CHAR) return SEXTET_PAD;
    return SEXTET_BAD;
  endfunction

  task automatic push_result(input logic [7:0] d, input logic dv, input logic l,
                             input logic e);
    b64_result_t r;
    r.data = d;
    r.dv   = dv;
    r.last = l;
    r.err  = e;
    base64_expected.push_back(r);
  endtask

  task automatic clear_group();
    pred_count = 2'd0;
    pred_held  = 18'd0;
  endtask

  task automatic flush_decoded(input logic [23:0] v, input int n);
    case (n)
      4: begin
        push_result(v[23:16], 1'b1, 1'b0, 1'b0);
        push_result(v[15:8], 1'b1, 1'b0, 1'b0);
        push_result(v[7:0], 1'b1, 1'b1, 1'b0);
      end
      3: begin
        push_result(v[17:10], 1'b1, 1'b0, 1'b0);
        push_result(v[9:2], 1'b1, 1'b1, 1'b0);
      end
      2: push_result(v[11:4], 1'b1, 1'b1, 1'b0);
      default: push_result(8'h00, 1'b0, 1'b1, 1'b0);
    endcase
  endtask

  task automatic predict_base64(input logic [7:0] d, input logic l);
    logic [23:0] v;
    int          n;
    int          s;
    if (pred_drop) begin
      if (l) begin
        pred_drop = 1'b0;
        clear_group();
      end
      return;
    end
    items_live++;
    if (pred_mode == b64c_pkg::MODE_ENC) begin
      n = pred_count + 1;
      v = {pred_held[15:0], d};
      if (n < 3 && !l) begin
        pred_held  = {2'b00, v[15:0]};
        pred_count = n[1:0];
        return;
      end
      if (n == 1) v = v << 16;
      else if (n == 2) v = v << 8;
      clear_group();
      push_result(b64_alphabet[v[23:18]], 1'b1, 1'b0, 1'b0);
      push_result(b64_alphabet[v[17:12]], 1'b1, 1'b0, 1'b0);
      push_result((n >= 2) ? b64_alphabet[v[11:6]] : b64c_pkg::PAD_CHAR,
                  1'b1, 1'b0, 1'b0);
      push_result((n >= 3) ? b64_alphabet[v[5:0]] : b64c_pkg::PAD_CHAR,
                  1'b1, l, 1'b0);
      return;
    end
    s = sextet_of(d);
    if (s == SEXTET_BAD) begin
      clear_group();
      pred_drop = !l;
      push_result(8'h00, 1'b0, 1'b1, 1'b1);
      return;
    end
    if (s == SEXTET_PAD) begin
      flush_decoded({6'd0, pred_held}, pred_count);
      clear_group();
      pred_drop = !l;
      return;
    end
    n = pred_count + 1;
    v = {pred_held, s[5:0]};
    if (l) begin
      clear_group();
      flush_decoded(v, n);
      return;
    end
    if (n < 4) begin
      pred_held  = v[17:0];
      pred_count = n[1:0];
      return;
    end
    clear_group();
    push_result(v[23:16], 1'b1, 1'b0, 1'b0);
    push_result(v[15:8], 1'b1, 1'b0, 1'b0);
    push_result(v[7:0], 1'b1, 1'b0, 1'b0);
  endtask

  // hold off idle cycles, then offer the item until it is taken
  task automatic send_item(input logic [7:0] d, input logic l);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_base64(d, l);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], close && (i == s.len() - 1));
    end
  endtask

  task automatic set_mode(input logic m);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (base64_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pred_mode = m;
    pred_drop = 1'b0;
    clear_group();
    @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    b64_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser[1]) error_results++;
      if (base64_expected.size() == 0) begin
        $error("unexpected result: data %0h dv %0b last %0b err %0b",
               out_tdata, out_tuser[0], out_tlast, out_tuser[1]);
        fails++;
      end else begin
        want = base64_expected.pop_front();
        if (out_tdata !== want.data) begin
          $error("data_out: expected %0h, actual %0h", want.data, out_tdata);
          fails++;
        end
        if (out_tuser[0] !== want.dv) begin
          $error("data_valid: expected %0b, actual %0b", want.dv, out_tuser[0]);
          fails++;
        end
        if (out_tlast !== want.last) begin
          $error("last_out: expected %0b, actual %0b", want.last, out_tlast);
          fails++;
        end
        if (out_tuser[1] !== want.err) begin
          $error("error: expected %0b, actual %0b", want.err, out_tuser[1]);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic test_encode_directed();
    send_text("Man", 1'b1);
    send_text("Ma", 1'b1);
    send_text("M", 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h7F, 1'b1);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
  endtask

  task automatic test_decode_directed();
    set_mode(1'b1);
    send_text("TWFu", 1'b1);
    send_text("TWE=", 1'b0);
    send_text("TQ==", 1'b1);
    send_text("T", 1'b1);
    send_text("=", 1'b1);
    send_text("Q=", 1'b1);
    send_text("*AB", 1'b1);
    send_text("AZ!", 1'b1);
    send_text("+/09za", 1'b1);
  endtask

  task automatic test_mode_switch();
    set_mode(1'b0);
    send_text("AB", 1'b0);
    set_mode(1'b1);
    send_text("QUI=", 1'b1);
    send_text("QU", 1'b0);
    set_mode(1'b1);
    send_text("*x", 1'b0);
    set_mode(1'b1);
    send_text("QQ==", 1'b1);
    send_text("QU", 1'b0);
    set_mode(1'b0);
    send_text("A", 1'b1);
  endtask

  task automatic test_backpressure();
    set_mode(1'b0);
    hold_request = 1'b1;
    for (int i = 0; i < 36; i++) begin
      send_item(8'($urandom_range(255)), i == 35);
    end
  endtask

  task automatic test_random_streams();
    int streams;
    int len;
    int ending;
    streams = 0;
    while (items_sent < 170) begin
      if (streams % 6 == 0) set_mode(1'($urandom_range(1)));
      steady = (streams >= 2 && streams < 8);
      if (pred_mode == b64c_pkg::MODE_ENC) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) send_item(8'($urandom_range(255)), i == len - 1);
      end else if ($urandom_range(99) < 80) begin
        len    = $urandom_range(1, 11);
        ending = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
          send_item(b64_alphabet[$urandom_range(63)], (i == len - 1) && (ending == 0));
        end
        if (ending == 1) send_item(b64c_pkg::PAD_CHAR, 1'b1);
        if (ending == 2) begin
          send_item(b64c_pkg::PAD_CHAR, 1'b0);
          send_item(b64c_pkg::PAD_CHAR, 1'b1);
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send_item(8'($urandom_range(255)), (i == len - 1) || ($urandom_range(3) == 0));
        end
      end
      streams++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encode_directed();
    test_decode_directed();
    test_mode_switch();
    test_backpressure();
    test_random_streams();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (base64_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items (%0d not dropped), checked %0d results, %0d of them errors.",
             items_sent, items_live, results_seen, error_results);
    $display("Both modes, padded and unpadded tails, drops, mode writes and a long stall.");
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
